/* hdl/clfp_pkg.sv */
package clfp_pkg;

   localparam int PAGE_BYTES_DEFAULT = 1024;
   localparam int RECORD_BYTES_W = 10;
   localparam int STEP_W = 5;

   localparam logic [7:0] NONE_MARK = 8'hFF;

   localparam logic [31:0] BASE_ADDRESS_RESET = 32'd0;
   localparam logic [7:0] PAGE_COUNT_RESET = 8'd1;
   localparam logic [RECORD_BYTES_W-1:0] RECORD_BYTES_RESET = 10'd4;
   localparam logic [7:0] RECORDS_PER_PAGE_RESET = 8'd255;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_LOCATE_BACK = 2'd1,
      OP_LOCATE_DIRECT = 2'd2,
      OP_CLEAR = 2'd3
   } op_code_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_BASE_ADDRESS = 2'd0,
      CSR_PAGE_COUNT = 2'd1,
      CSR_RECORD_BYTES = 2'd2,
      CSR_RECORDS_PER_PAGE = 2'd3
   } csr_index_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_INIT,
      DP_MUL_LIMIT,
      DP_DIV_LOAD,
      DP_DIV_STEP,
      DP_SET_FAR,
      DP_PG_BACK,
      DP_PG_WRAP,
      DP_NEAR,
      DP_DIR_LOAD,
      DP_MUL_PAGE,
      DP_ADD_PAGE,
      DP_ADD_REC,
      DP_BAD,
      DP_EMPTY,
      DP_CLEAR,
      DP_WR_LOAD,
      DP_PAGE_ADV,
      DP_PAGE_WRAP
   } dp_op_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_OP_WRITE,
      COND_OP_CLEAR,
      COND_OP_DIRECT,
      COND_EMPTY,
      COND_OFF_GE_LIMIT,
      COND_OFF_LE_IDX,
      COND_DIV_MORE,
      COND_BACK_GT_LAST,
      COND_BOUNDS_BAD,
      COND_NI_LT_RPP
   } cond_type;

   typedef struct packed {
      logic op_write;
      logic op_clear;
      logic op_direct;
      logic empty;
      logic off_ge_limit;
      logic off_le_idx;
      logic div_more;
      logic back_gt_last;
      logic bounds_bad;
      logic ni_lt_rpp;
   } cond_flags_type;

   typedef struct packed {
      logic [31:0] base_address;
      logic [7:0] page_count;
      logic [RECORD_BYTES_W-1:0] record_bytes;
      logic [7:0] records_per_page;
   } cfg_type;

   typedef struct packed {
      dp_op_type op;
      cond_type cond;
      logic [STEP_W-1:0] target;
      logic done;
   } ucode_word_type;

endpackage

/* hdl/clfp_sequencer.sv */
module clfp_sequencer import clfp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic start_accept,
   input  cond_flags_type flags,
   output dp_op_type dp_op,
   output logic busy,
   output logic rsp_strobe
);

   localparam logic [STEP_W-1:0] L_NEAR = 5'd13;
   localparam logic [STEP_W-1:0] L_CHECK = 5'd14;
   localparam logic [STEP_W-1:0] L_ADDR = 5'd15;
   localparam logic [STEP_W-1:0] L_BAD = 5'd18;
   localparam logic [STEP_W-1:0] L_EMPTY = 5'd19;
   localparam logic [STEP_W-1:0] L_CLEAR = 5'd20;
   localparam logic [STEP_W-1:0] L_DIRECT = 5'd21;
   localparam logic [STEP_W-1:0] L_WRITE = 5'd22;
   localparam logic [STEP_W-1:0] L_DIV = 5'd8;
   localparam logic [STEP_W-1:0] L_WRAP = 5'd12;
   localparam logic [STEP_W-1:0] LAST_STEP = 5'd25;
   localparam logic [STEP_W-1:0] NO_TARGET = 5'd0;

   seq_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic strobe_ff, strobe_in;
   ucode_word_type word;
   logic take;

   function automatic ucode_word_type rom(input logic [STEP_W-1:0] step);
      ucode_word_type w;
      begin
         unique case (step)
            5'd0: w = '{DP_INIT, COND_OP_WRITE, L_WRITE, 1'b0};
            5'd1: w = '{DP_NOP, COND_OP_CLEAR, L_CLEAR, 1'b0};
            5'd2: w = '{DP_NOP, COND_EMPTY, L_EMPTY, 1'b0};
            5'd3: w = '{DP_NOP, COND_OP_DIRECT, L_DIRECT, 1'b0};
            5'd4: w = '{DP_MUL_LIMIT, COND_NEVER, NO_TARGET, 1'b0};
            5'd5: w = '{DP_NOP, COND_OFF_GE_LIMIT, L_BAD, 1'b0};
            5'd6: w = '{DP_NOP, COND_OFF_LE_IDX, L_NEAR, 1'b0};
            5'd7: w = '{DP_DIV_LOAD, COND_NEVER, NO_TARGET, 1'b0};
            5'd8: w = '{DP_DIV_STEP, COND_DIV_MORE, L_DIV, 1'b0};
            5'd9: w = '{DP_SET_FAR, COND_NEVER, NO_TARGET, 1'b0};
            5'd10: w = '{DP_NOP, COND_BACK_GT_LAST, L_WRAP, 1'b0};
            5'd11: w = '{DP_PG_BACK, COND_ALWAYS, L_CHECK, 1'b0};
            5'd12: w = '{DP_PG_WRAP, COND_ALWAYS, L_CHECK, 1'b0};
            5'd13: w = '{DP_NEAR, COND_NEVER, NO_TARGET, 1'b0};
            5'd14: w = '{DP_NOP, COND_BOUNDS_BAD, L_BAD, 1'b0};
            5'd15: w = '{DP_MUL_PAGE, COND_NEVER, NO_TARGET, 1'b0};
            5'd16: w = '{DP_ADD_PAGE, COND_NEVER, NO_TARGET, 1'b0};
            5'd17: w = '{DP_ADD_REC, COND_NEVER, NO_TARGET, 1'b1};
            5'd18: w = '{DP_BAD, COND_NEVER, NO_TARGET, 1'b1};
            5'd19: w = '{DP_EMPTY, COND_NEVER, NO_TARGET, 1'b1};
            5'd20: w = '{DP_CLEAR, COND_NEVER, NO_TARGET, 1'b1};
            5'd21: w = '{DP_DIR_LOAD, COND_ALWAYS, L_CHECK, 1'b0};
            5'd22: w = '{DP_WR_LOAD, COND_NEVER, NO_TARGET, 1'b0};
            5'd23: w = '{DP_NOP, COND_NI_LT_RPP, L_ADDR, 1'b0};
            5'd24: w = '{DP_PAGE_ADV, COND_NEVER, NO_TARGET, 1'b0};
            5'd25: w = '{DP_PAGE_WRAP, COND_ALWAYS, L_ADDR, 1'b0};
            default: w = '{DP_NOP, COND_NEVER, NO_TARGET, 1'b1};
         endcase
         return w;
      end
   endfunction

   always_comb begin
      word = rom(step_ff);
      unique case (word.cond)
         COND_NEVER: take = 1'b0;
         COND_ALWAYS: take = 1'b1;
         COND_OP_WRITE: take = flags.op_write;
         COND_OP_CLEAR: take = flags.op_clear;
         COND_OP_DIRECT: take = flags.op_direct;
         COND_EMPTY: take = flags.empty;
         COND_OFF_GE_LIMIT: take = flags.off_ge_limit;
         COND_OFF_LE_IDX: take = flags.off_le_idx;
         COND_DIV_MORE: take = flags.div_more;
         COND_BACK_GT_LAST: take = flags.back_gt_last;
         COND_BOUNDS_BAD: take = flags.bounds_bad;
         COND_NI_LT_RPP: take = flags.ni_lt_rpp;
         default: take = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         strobe_ff <= strobe_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      strobe_in = 1'b0;
      dp_op = DP_NOP;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start_accept) begin
               state_in = SEQ_RUN;
               step_in = '0;
            end
         end
         SEQ_RUN: begin
            dp_op = word.op;
            if (word.done) begin
               state_in = SEQ_IDLE;
               step_in = '0;
               strobe_in = 1'b1;
            end else if (take) begin
               step_in = word.target;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   assign busy = (state_ff == SEQ_RUN);
   assign rsp_strobe = strobe_ff;

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      start_accept |=> (state_ff == SEQ_RUN && step_ff == '0))
      else $error("Accepted beat did not start the program at step zero.");

   a_strobe_after_run: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> ($past(state_ff == SEQ_RUN) && state_ff == SEQ_IDLE))
      else $error("Result strobe without a finished program.");

   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_RUN) |-> (step_ff <= LAST_STEP))
      else $error("Step counter left the program.");
`endif

endmodule

/* hdl/clfp_datapath.sv */
module clfp_datapath import clfp_pkg::*; #(
   parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic start_accept,
   input  logic [1:0] req_operation,
   input  logic [15:0] req_offset,
   input  logic [7:0] req_page_number,
   input  logic [7:0] req_record_index,
   input  cfg_type cfg,
   input  dp_op_type dp_op,
   output cond_flags_type flags,
   output logic [1:0] rsp_status,
   output logic [31:0] rsp_record_address,
   output logic rsp_header_write,
   output logic [31:0] rsp_header_address,
   output logic [30:0] rsp_header_serial,
   output logic [7:0] rsp_newest_page,
   output logic [7:0] rsp_newest_index
);

   localparam int PB_W = $clog2(PAGE_BYTES + 1);
   localparam int BW = (PB_W > RECORD_BYTES_W) ? PB_W : RECORD_BYTES_W;
   localparam int PW = BW + 8;
   localparam logic [BW-1:0] PAGE_BYTES_W = BW'(PAGE_BYTES);

   op_code_type op_ff, op_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0] pgin_ff, pgin_in;
   logic [7:0] recin_ff, recin_in;
   logic [7:0] next_page_ff, next_page_in;
   logic [7:0] next_index_ff, next_index_in;
   logic [7:0] last_page_ff, last_page_in;
   logic [7:0] last_index_ff, last_index_in;
   logic [30:0] serial_ff, serial_in;
   logic [7:0] pg_ff, pg_in;
   logic [7:0] rec_ff, rec_in;
   logic [7:0] back_ff, back_in;
   logic [15:0] q_ff, q_in;
   logic [7:0] r_ff, r_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [31:0] acc_ff, acc_in;
   status_type status_ff, status_in;
   logic [31:0] raddr_ff, raddr_in;
   logic hw_ff, hw_in;
   logic [31:0] haddr_ff, haddr_in;
   logic [30:0] hser_ff, hser_in;

   logic [7:0] mul_a;
   logic [BW-1:0] mul_b;
   logic [8:0] div_trial;
   logic div_ge;
   logic [31:0] prod_ext;

   assign prod_ext = 32'(prod_ff);
   assign div_trial = {r_ff, q_ff[15]};
   assign div_ge = (div_trial >= {1'b0, cfg.records_per_page});

   always_comb begin
      mul_a = rec_ff;
      mul_b = BW'(cfg.record_bytes);
      unique case (dp_op)
         DP_MUL_LIMIT: begin
            mul_a = cfg.page_count;
            mul_b = BW'(cfg.records_per_page);
         end
         DP_MUL_PAGE: begin
            mul_a = pg_ff;
            mul_b = PAGE_BYTES_W;
         end
         default: begin
            mul_a = rec_ff;
            mul_b = BW'(cfg.record_bytes);
         end
      endcase
   end

   always_comb begin
      flags.op_write = (op_ff == OP_WRITE);
      flags.op_clear = (op_ff == OP_CLEAR);
      flags.op_direct = (op_ff == OP_LOCATE_DIRECT);
      flags.empty = (last_page_ff == NONE_MARK);
      flags.off_ge_limit = (PW'(offset_ff) >= prod_ff);
      flags.off_le_idx = (offset_ff <= 16'(last_index_ff));
      flags.div_more = (cnt_ff != 4'hF);
      flags.back_gt_last = (back_ff > last_page_ff);
      flags.bounds_bad = (pg_ff >= cfg.page_count) || (rec_ff >= cfg.records_per_page);
      flags.ni_lt_rpp = (next_index_ff < cfg.records_per_page);
   end

   always_comb begin
      op_in = op_ff;
      offset_in = offset_ff;
      pgin_in = pgin_ff;
      recin_in = recin_ff;
      next_page_in = next_page_ff;
      next_index_in = next_index_ff;
      last_page_in = last_page_ff;
      last_index_in = last_index_ff;
      serial_in = serial_ff;
      pg_in = pg_ff;
      rec_in = rec_ff;
      back_in = back_ff;
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      status_in = status_ff;
      raddr_in = raddr_ff;
      hw_in = hw_ff;
      haddr_in = haddr_ff;
      hser_in = hser_ff;

      if (start_accept) begin
         op_in = op_code_type'(req_operation);
         offset_in = req_offset;
         pgin_in = req_page_number;
         recin_in = req_record_index;
      end

      unique case (dp_op)
         DP_INIT: begin
            status_in = STATUS_OK;
            raddr_in = '0;
            hw_in = 1'b0;
            haddr_in = '0;
            hser_in = '0;
         end
         DP_MUL_LIMIT: prod_in = PW'(mul_a) * PW'(mul_b);
         DP_DIV_LOAD: begin
            q_in = offset_ff - 16'(last_index_ff) - 16'd1;
            r_in = '0;
            cnt_in = '0;
         end
         DP_DIV_STEP: begin
            q_in = {q_ff[14:0], div_ge};
            r_in = div_ge ? 8'(div_trial - {1'b0, cfg.records_per_page}) : div_trial[7:0];
            cnt_in = cnt_ff + 4'd1;
         end
         DP_SET_FAR: begin
            rec_in = cfg.records_per_page - 8'd1 - r_ff;
            back_in = q_ff[7:0] + 8'd1;
         end
         DP_PG_BACK: pg_in = last_page_ff - back_ff;
         DP_PG_WRAP: pg_in = cfg.page_count + last_page_ff - back_ff;
         DP_NEAR: begin
            pg_in = last_page_ff;
            rec_in = last_index_ff - offset_ff[7:0];
         end
         DP_DIR_LOAD: begin
            pg_in = pgin_ff;
            rec_in = recin_ff;
         end
         DP_MUL_PAGE: prod_in = PW'(mul_a) * PW'(mul_b);
         DP_ADD_PAGE: begin
            acc_in = cfg.base_address + prod_ext;
            prod_in = PW'(mul_a) * PW'(mul_b);
         end
         DP_ADD_REC: begin
            raddr_in = acc_ff + prod_ext + 32'd4;
            if (hw_ff) begin
               haddr_in = acc_ff;
            end
         end
         DP_BAD: status_in = STATUS_RANGE;
         DP_EMPTY: status_in = STATUS_EMPTY;
         DP_CLEAR: begin
            next_page_in = '0;
            next_index_in = '0;
            last_page_in = NONE_MARK;
            last_index_in = NONE_MARK;
            serial_in = '0;
         end
         DP_WR_LOAD: begin
            pg_in = next_page_ff;
            rec_in = next_index_ff;
            last_page_in = next_page_ff;
            last_index_in = next_index_ff;
            next_index_in = next_index_ff + 8'd1;
            if (next_index_ff == 8'd0) begin
               hw_in = 1'b1;
               hser_in = serial_ff;
            end
         end
         DP_PAGE_ADV: begin
            next_index_in = '0;
            serial_in = serial_ff + 31'd1;
            next_page_in = next_page_ff + 8'd1;
         end
         DP_PAGE_WRAP: begin
            if (next_page_ff >= cfg.page_count) begin
               next_page_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_page_ff <= '0;
         next_index_ff <= '0;
         last_page_ff <= NONE_MARK;
         last_index_ff <= NONE_MARK;
         serial_ff <= '0;
      end else begin
         next_page_ff <= next_page_in;
         next_index_ff <= next_index_in;
         last_page_ff <= last_page_in;
         last_index_ff <= last_index_in;
         serial_ff <= serial_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      offset_ff <= offset_in;
      pgin_ff <= pgin_in;
      recin_ff <= recin_in;
      pg_ff <= pg_in;
      rec_ff <= rec_in;
      back_ff <= back_in;
      q_ff <= q_in;
      r_ff <= r_in;
      cnt_ff <= cnt_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      status_ff <= status_in;
      raddr_ff <= raddr_in;
      hw_ff <= hw_in;
      haddr_ff <= haddr_in;
      hser_ff <= hser_in;
   end

   assign rsp_status = status_ff;
   assign rsp_record_address = raddr_ff;
   assign rsp_header_write = hw_ff;
   assign rsp_header_address = haddr_ff;
   assign rsp_header_serial = hser_ff;
   assign rsp_newest_page = last_page_ff;
   assign rsp_newest_index = last_index_ff;

endmodule

/* hdl/circular_flash_log_pointer_core.sv */
// Address generator for a ring of flash pages, run by a microcoded sequencer over one shared
// datapath. A command beat is taken when start is high and busy is low; its result appears for
// exactly one cycle with rsp_strobe, and the receiver cannot stall it. The block stays busy
// until that result and takes no new beat meanwhile; the next beat can be taken in the strobe
// cycle. Item kinds: clear, lookups before any write, an offset at or beyond the ring size, a
// write with or without a page change, a direct locate, a lookup within the newest page, and a
// lookup reaching back past the newest page, which runs a 16-step restoring divide of the
// offset less the newest index and one by records per page. Registers are to be written
// through the csr port only while the block is idle, by the user; the block does not enforce it.
module circular_flash_log_pointer_core import clfp_pkg::*; #(
   parameter int PAGE_BYTES = PAGE_BYTES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_operation,
   input  logic [15:0] req_offset,
   input  logic [7:0] req_page_number,
   input  logic [7:0] req_record_index,
   output logic rsp_strobe,
   output logic [1:0] rsp_status,
   output logic [31:0] rsp_record_address,
   output logic rsp_header_write,
   output logic [31:0] rsp_header_address,
   output logic [30:0] rsp_header_serial,
   output logic [7:0] rsp_newest_page,
   output logic [7:0] rsp_newest_index,
   input  logic csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   cond_flags_type flags;
   dp_op_type dp_op;
   logic start_accept;

   assign start_accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_BASE_ADDRESS: cfg_in.base_address = csr_write_data;
            CSR_PAGE_COUNT: cfg_in.page_count = csr_write_data[7:0];
            CSR_RECORD_BYTES: cfg_in.record_bytes = csr_write_data[RECORD_BYTES_W-1:0];
            CSR_RECORDS_PER_PAGE: cfg_in.records_per_page = csr_write_data[7:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address <= BASE_ADDRESS_RESET;
         cfg_ff.page_count <= PAGE_COUNT_RESET;
         cfg_ff.record_bytes <= RECORD_BYTES_RESET;
         cfg_ff.records_per_page <= RECORDS_PER_PAGE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clfp_sequencer u_sequencer (
      .clock(clock),
      .reset(reset),
      .start_accept(start_accept),
      .flags(flags),
      .dp_op(dp_op),
      .busy(busy),
      .rsp_strobe(rsp_strobe)
   );

   clfp_datapath #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .start_accept(start_accept),
      .req_operation(req_operation),
      .req_offset(req_offset),
      .req_page_number(req_page_number),
      .req_record_index(req_record_index),
      .cfg(cfg_ff),
      .dp_op(dp_op),
      .flags(flags),
      .rsp_status(rsp_status),
      .rsp_record_address(rsp_record_address),
      .rsp_header_write(rsp_header_write),
      .rsp_header_address(rsp_header_address),
      .rsp_header_serial(rsp_header_serial),
      .rsp_newest_page(rsp_newest_page),
      .rsp_newest_index(rsp_newest_index)
   );

endmodule
